/* hdl/twrtc_pkg.sv */
// Shared types and constants for the three-wire RTC serial master.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package twrtc_pkg;

    localparam int BYTE_BITS  = 8;
    localparam int SHIFT_BITS = 2 * BYTE_BITS;
    localparam int PHASE_BITS = 6;

    // Request codes on the input channel
    localparam logic [1:0] REQ_START_WR = 2'd0;
    localparam logic [1:0] REQ_START_RD = 2'd1;
    localparam logic [1:0] REQ_TICK     = 2'd2;

    // Forced into bit 0 of the command byte on a read
    localparam logic [BYTE_BITS-1:0] READ_FLAG = 8'h01;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [BYTE_BITS-1:0] command;
        logic [BYTE_BITS-1:0] write_data;
        logic                 io_in;
    } t_in_item;

    typedef struct packed {
        logic                 chip_enable;
        logic                 serial_clock;
        logic                 io_out;
        logic                 io_drive;
        logic [BYTE_BITS-1:0] read_data;
        logic                 done_res;
        logic                 rejected;
    } t_out_item;

    // Operation after classification
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_TICK  = 2'd1,
        OP_NOP   = 2'd2
    } t_op;

    // Queue entry passed from the front end to the sequencer
    typedef struct packed {
        t_op                   op;
        logic                  is_read;
        logic [SHIFT_BITS-1:0] shift_word;
        logic                  io_in;
    } t_cmd;

    typedef struct packed {
        logic drv;
        logic io;
        logic sclk;
        logic ce;
    } t_pins;

    localparam t_pins PINS_IDLE = '{drv: 1'b1, io: 1'b0, sclk: 1'b0, ce: 1'b0};

endpackage

`default_nettype wire

/* hdl/three_wire_rtc_serial_master_core.sv */
// Top level of the three-wire RTC serial master: front end, queue, sequencer.
// Depends on twrtc_pkg, twrtc_front, twrtc_queue and twrtc_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one beat per
//   request: start write, start read, or a tick that advances the pins by one
//   half bit. Every input beat yields exactly one result beat on the output
//   channel (o_out_valid / i_out_ready / o_out_item) with the pin levels after
//   that beat, done on the closing tick, the read byte on a read's closing
//   tick, and the rejected flag for a start that arrives mid-transaction.
//   A transaction is its start beat plus 33 ticks.
//   A taken beat is written into the command queue, then popped by the
//   sequencer into its result register. Throughput is one beat per cycle
//   while the queue is not full; the sequencer retires one queued command
//   per cycle while its result register is empty or being drained, so a
//   stalled result holds the queue's head back.
//   Reset (synchronous, active low) empties the queue, drops the pending
//   result and returns the pins to idle: CE low, SCLK low, IO driven low.
//   When the receiver stalls the result is held stable, the sequencer stops,
//   and the queue absorbs up to QUEUE_DEPTH beats before o_in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module three_wire_rtc_serial_master_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire twrtc_pkg::t_in_item i_in_item,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output twrtc_pkg::t_out_item     o_out_item
);

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    twrtc_pkg::t_cmd front_cmd;
    twrtc_pkg::t_cmd head_cmd;

    // Decode the request and push it when the queue has room
    twrtc_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    // Decouple acceptance from sequencing
    twrtc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    // Advance the pin pattern and register one result per command
    twrtc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

/* hdl/twrtc_front.sv */
// Front end of the RTC serial master: accepts input beats and classifies them.
// Depends on twrtc_pkg; feeds twrtc_queue.
`timescale 1ns / 1ps
`default_nettype none

module twrtc_front (
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire twrtc_pkg::t_in_item i_in_item,
    input  wire                      i_full,
    output logic                     o_push,
    output twrtc_pkg::t_cmd          o_cmd
);

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        o_cmd            = '0;
        o_cmd.io_in      = i_in_item.io_in;
        o_cmd.shift_word = {i_in_item.write_data, i_in_item.command};
        unique case (i_in_item.req_type)
            twrtc_pkg::REQ_START_WR: begin
                o_cmd.op      = twrtc_pkg::OP_START;
                o_cmd.is_read = 1'b0;
            end
            twrtc_pkg::REQ_START_RD: begin
                // read sends only the command byte, with the read flag forced
                o_cmd.op         = twrtc_pkg::OP_START;
                o_cmd.is_read    = 1'b1;
                o_cmd.shift_word = {{twrtc_pkg::BYTE_BITS{1'b0}},
                                    i_in_item.command | twrtc_pkg::READ_FLAG};
            end
            twrtc_pkg::REQ_TICK: begin
                o_cmd.op = twrtc_pkg::OP_TICK;
            end
            default: begin
                o_cmd.op = twrtc_pkg::OP_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/twrtc_queue.sv */
// Short FIFO of classified commands between front end and sequencer.
// Depends on twrtc_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module twrtc_queue #(
    parameter int DEPTH = 2
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire twrtc_pkg::t_cmd i_cmd,
    input  wire                  i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output twrtc_pkg::t_cmd      o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    twrtc_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* hdl/twrtc_back.sv */
// Sequencer of the RTC serial master: steps the pin pattern and holds the result.
// Depends on twrtc_pkg; drains twrtc_queue.
`timescale 1ns / 1ps
`default_nettype none

module twrtc_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_empty,
    input  wire twrtc_pkg::t_cmd i_cmd,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output twrtc_pkg::t_out_item o_out_item
);

    localparam int BB = twrtc_pkg::BYTE_BITS;
    localparam int SB = twrtc_pkg::SHIFT_BITS;
    localparam int PB = twrtc_pkg::PHASE_BITS;

    logic                 r_busy,      n_busy;
    logic                 r_is_read,   n_is_read;
    logic [PB-1:0]        r_phase,     n_phase;
    logic [SB-1:0]        r_shift_out, n_shift_out;
    logic [BB-1:0]        r_shift_in,  n_shift_in;
    twrtc_pkg::t_pins     r_pins,      n_pins;
    logic                 r_out_valid;
    twrtc_pkg::t_out_item r_out,       n_out;

    logic done;
    logic rej;

    // Take the next command whenever the result slot is free or being drained
    assign o_pop       = !i_empty && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_busy      = r_busy;
        n_is_read   = r_is_read;
        n_phase     = r_phase;
        n_shift_out = r_shift_out;
        n_shift_in  = r_shift_in;
        n_pins      = r_pins;
        done        = 1'b0;
        rej         = 1'b0;

        unique case (i_cmd.op)
            twrtc_pkg::OP_START: begin
                if (r_busy) begin
                    rej = 1'b1;
                end else begin
                    n_busy      = 1'b1;
                    n_is_read   = i_cmd.is_read;
                    n_phase     = '0;
                    n_shift_in  = '0;
                    n_shift_out = i_cmd.shift_word;
                    n_pins      = '{drv: 1'b1, io: 1'b0, sclk: 1'b0, ce: 1'b1};
                end
            end
            twrtc_pkg::OP_TICK: begin
                if (r_busy) begin
                    n_phase = r_phase + 1'b1;
                    if (r_phase[PB-1]) begin
                        // end of transaction
                        n_pins  = twrtc_pkg::PINS_IDLE;
                        done    = 1'b1;
                        n_busy  = 1'b0;
                        n_phase = '0;
                    end else if (r_is_read && r_phase[PB-2]) begin
                        if (!r_phase[0]) begin
                            n_pins = '{drv: 1'b0, io: 1'b0, sclk: 1'b0, ce: 1'b1};
                        end else begin
                            n_shift_in[r_phase[3:1]] = r_shift_in[r_phase[3:1]]
                                                       | i_cmd.io_in;
                            n_pins = '{drv: 1'b0, io: 1'b0, sclk: 1'b1, ce: 1'b1};
                        end
                    end else begin
                        n_pins = '{drv: 1'b1, io: r_shift_out[r_phase[4:1]],
                                   sclk: r_phase[0], ce: 1'b1};
                    end
                end
            end
            default: begin
            end
        endcase

        n_out.chip_enable  = n_pins.ce;
        n_out.serial_clock = n_pins.sclk;
        n_out.io_out       = n_pins.io;
        n_out.io_drive     = n_pins.drv;
        n_out.read_data    = (done && r_is_read) ? r_shift_in : '0;
        n_out.done_res     = done;
        n_out.rejected     = rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_is_read   <= 1'b0;
            r_phase     <= '0;
            r_shift_out <= '0;
            r_shift_in  <= '0;
            r_pins      <= twrtc_pkg::PINS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy      <= n_busy;
                r_is_read   <= n_is_read;
                r_phase     <= n_phase;
                r_shift_out <= n_shift_out;
                r_shift_in  <= n_shift_in;
                r_pins      <= n_pins;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

/* hdl/twrtc_checker.sv */
// Port-level checks for the three-wire RTC serial master, bound to the top level.
// Depends on twrtc_pkg and three_wire_rtc_serial_master_core.
`timescale 1ns / 1ps
`default_nettype none

module twrtc_checker (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       o_out_valid,
    input wire                       i_out_ready,
    input wire twrtc_pkg::t_out_item o_out_item
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result beat changed while stalled");

    // Closing tick leaves the pins idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.done_res |->
            !o_out_item.chip_enable && !o_out_item.serial_clock &&
            o_out_item.io_drive && !o_out_item.io_out)
        else $error("done without idle pins");

    // Rejection only happens mid-transaction
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.rejected |->
            o_out_item.chip_enable && !o_out_item.done_res)
        else $error("rejected outside a transaction");

    // Released line only during a read with CE high, and never driven high
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.io_drive |->
            o_out_item.chip_enable && !o_out_item.io_out)
        else $error("line released outside a read");

    // Read byte appears only on the closing tick
    a_rd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.read_data != '0) |-> o_out_item.done_res)
        else $error("read data outside done");

endmodule

bind three_wire_rtc_serial_master_core twrtc_checker u_twrtc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire
